/* design/cstp_pkg.sv */
package cstp_pkg;

    localparam int TS_W   = 48;
    localparam int CNT_W  = 32;
    localparam int REF_W  = 9;
    localparam int DEEP_W = 7;

    typedef enum logic [1:0] {
        OP_CALL   = 2'd0,
        OP_RETURN = 2'd1,
        OP_FRAME  = 2'd2,
        OP_STATS  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_RETURN   = 2'd0,
        KIND_FRAME    = 2'd1,
        KIND_STATS    = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    localparam logic CFG_EMIT_EDGES  = 1'b0;
    localparam logic CFG_EMIT_FRAMES = 1'b1;

    localparam logic [REF_W-1:0] NONE_REF = 9'd256;
    localparam logic [TS_W-1:0]  MAX48    = {TS_W{1'b1}};
    localparam logic [CNT_W-1:0] MAX32    = {CNT_W{1'b1}};

    // Per-function statistics entry, kept in one memory word.
    typedef struct packed {
        logic [CNT_W-1:0]  calls;
        logic [DEEP_W-1:0] active;
        logic [TS_W-1:0]   incl;
        logic [TS_W-1:0]   excl;
        logic [TS_W-1:0]   tmin;
        logic [TS_W-1:0]   tmax;
        logic [DEEP_W-1:0] deep;
    } t_fstat;

    typedef struct packed {
        logic [7:0]      func;
        logic [TS_W-1:0] start;
        logic [TS_W-1:0] child;
    } t_frame_ent;

    typedef struct packed {
        logic [1:0]        kind;
        logic [REF_W-1:0]  func_ref;
        logic [REF_W-1:0]  caller_ref;
        logic [TS_W-1:0]   inclusive_time;
        logic [TS_W-1:0]   exclusive_time;
        logic [CNT_W-1:0]  event_count;
        logic [TS_W-1:0]   min_time;
        logic [TS_W-1:0]   max_time;
        logic [DEEP_W-1:0] deepest;
        logic [CNT_W-1:0]  frame_number;
        logic [TS_W-1:0]   frame_script_time;
    } t_rec;

    function automatic logic [TS_W-1:0] add_sat48(input logic [TS_W-1:0] a,
                                                  input logic [TS_W-1:0] b);
        logic [TS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TS_W] ? MAX48 : s[TS_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] inc_sat32(input logic [CNT_W-1:0] a);
        return (a == MAX32) ? a : a + 1'b1;
    endfunction

endpackage

/* design/cstp_ram.sv */
module cstp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* design/call_stack_time_profiler.sv */
// Call stack time profiler.
// Events enter on the s_axis group: tdata holds func_id and timestamp, tuser
// holds the op (call, return, frame boundary, statistics read). Each event
// yields at most one record on the m_axis group: tdata holds the record
// fields, tuser the record kind. Two registers (emit_edges, emit_frames) are
// written on the cfg channel, index 0 and 1; the user must write them only
// while no event is in flight, which the block itself does not enforce.
// A call, frame boundary or statistics read executes on the table and stack
// words read at acceptance, then the block returns to idle for the next beat.
// A return first spends an extra read state, because its table read can only
// start once the stack top has named the function. The record is registered
// in the output register as the execute state ends.
// Reset empties the stack and then sweeps the function table to zero, one
// entry a cycle, all FUNCS entries, while s_axis_tready stays low.
// A stalled receiver holds the record in the output register; the next beat
// is taken only once that register is free or is emptied in the same cycle.
module call_stack_time_profiler
    import cstp_pkg::*;
#(
    parameter int FUNCS       = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,  // func_id[7:0], timestamp[55:8]
    input  logic [1:0]   s_axis_tuser,  // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // func_ref, caller_ref, inclusive_time, exclusive_time, event_count,
    // min_time, max_time, deepest, frame_number, frame_script_time, 0 pad
    output logic [335:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,  // kind
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic         i_cfg_data
);

    localparam int FA_W = $clog2(FUNCS);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int LV_W = $clog2(STACK_DEPTH + 1);
    localparam int FS_W = $bits(t_fstat);
    localparam int SE_W = $bits(t_frame_ent);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} t_state;

    t_state            r_state;
    logic [FA_W-1:0]   r_clr;
    logic [LV_W-1:0]   r_level;
    logic              r_edges, r_frames;
    t_op               r_op;
    logic [7:0]        r_fid;
    logic [TS_W-1:0]   r_ts;
    logic [TS_W-1:0]   r_fscript, r_ftop_time;
    logic [CNT_W-1:0]  r_fcalls, r_frames_seen;
    logic [REF_W-1:0]  r_ftop_func;
    logic              r_ovalid;
    t_rec              r_rec;

    // Function table and stack memories.
    logic              tab_we;
    logic [FA_W-1:0]   tab_waddr, tab_raddr;
    t_fstat            tab_wdata, tab_rdata;
    logic              stk_we;
    logic [SA_W-1:0]   stk_waddr, stk_raddr_top, stk_raddr_cal;
    t_frame_ent        stk_wdata, stk_top, stk_cal;

    cstp_ram #(.WIDTH(FS_W), .DEPTH(FUNCS)) u_tab (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_waddr), .i_wdata(tab_wdata),
        .i_raddr(tab_raddr), .o_rdata(tab_rdata)
    );
    // The top entry and its caller are read from two copies of the stack.
    cstp_ram #(.WIDTH(SE_W), .DEPTH(STACK_DEPTH)) u_stk_top (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr_top), .o_rdata(stk_top)
    );
    cstp_ram #(.WIDTH(SE_W), .DEPTH(STACK_DEPTH)) u_stk_cal (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr_cal), .o_rdata(stk_cal)
    );

    logic accept, out_free, full, empty, fid_ok;
    logic [7:0] in_fid;
    assign in_fid   = s_axis_tdata[7:0];
    assign out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && out_free;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign full  = (r_level >= LV_W'(STACK_DEPTH));
    assign empty = (r_level == '0);

    function automatic logic [SA_W-1:0] lvl_addr(input logic [LV_W-1:0] l);
        logic [LV_W-1:0] t;
        t = l;
        return t[SA_W-1:0];
    endfunction

    // Table address: the stack top's function on a return, else the id.
    // Clear reads at the sweep counter and idle at the incoming id; during
    // execution the selected function, which on a return is the popped one.
    logic [7:0] fsel;
    always_comb begin
        fsel = (r_op == OP_RETURN) ? stk_top.func : r_fid;
        fid_ok = (32'(fsel) < FUNCS);
        stk_raddr_top = lvl_addr(r_level - 1'b1);
        stk_raddr_cal = lvl_addr(r_level - 2'd2);
        if (r_state == ST_CLEAR) begin
            tab_raddr = r_clr;
        end else if (r_state == ST_EXEC) begin
            tab_raddr = FA_W'(fsel);
        end else begin
            tab_raddr = FA_W'(in_fid);
        end
    end

    // On a return the table address comes from the stack read, so a return
    // reads the table in an extra read state, with r_phase low, first.
    logic r_phase;

    logic [TS_W-1:0] incl, excl;
    t_fstat          upd;
    logic [DEEP_W-1:0] act_dec;
    logic [LV_W-1:0] lvl_new;
    t_rec            rec;
    logic            rec_v;

    always_comb begin
        incl = (r_ts > stk_top.start) ? r_ts - stk_top.start : '0;
        excl = (incl > stk_top.child) ? incl - stk_top.child : '0;
        upd  = tab_rdata;
        act_dec = (tab_rdata.active != '0) ? tab_rdata.active - 1'b1 : '0;
        lvl_new = r_level + 1'b1;
        tab_we = 1'b0;
        tab_waddr = FA_W'(fsel);
        stk_we = 1'b0;
        stk_waddr = lvl_addr(r_level);
        stk_wdata = '0;
        rec = '0;
        rec.func_ref = NONE_REF;
        rec_v = 1'b0;
        if (r_state == ST_CLEAR) begin
            tab_we = 1'b1;
            tab_waddr = r_clr;
            tab_wdata = '0;
        end else begin
            tab_wdata = upd;
        end
        if (r_state == ST_EXEC && r_phase) begin
            case (r_op)
                OP_CALL: begin
                    if (full) begin
                        rec_v = 1'b1;
                        rec.kind = KIND_OVERFLOW;
                        rec.func_ref = REF_W'(r_fid);
                    end else if (fid_ok) begin
                        upd.calls = inc_sat32(tab_rdata.calls);
                        if (32'(tab_rdata.active) < STACK_DEPTH)
                            upd.active = tab_rdata.active + 1'b1;
                        if (32'(lvl_new) > 32'(tab_rdata.deep))
                            upd.deep = DEEP_W'(lvl_new);
                        tab_wdata = upd;
                        tab_we = 1'b1;
                        stk_we = 1'b1;
                        stk_wdata.func = r_fid;
                        stk_wdata.start = r_ts;
                        stk_wdata.child = '0;
                    end
                end
                OP_RETURN: begin
                    if (!empty) begin
                        if (fid_ok) begin
                            upd.excl = add_sat48(tab_rdata.excl, excl);
                            upd.active = act_dec;
                            if (act_dec == '0) begin
                                upd.incl = add_sat48(tab_rdata.incl, incl);
                                if (incl > tab_rdata.tmax) upd.tmax = incl;
                                if (tab_rdata.tmin == '0 || incl < tab_rdata.tmin)
                                    upd.tmin = incl;
                            end
                            tab_wdata = upd;
                            tab_we = 1'b1;
                        end
                        if (r_level > LV_W'(1)) begin
                            stk_we = 1'b1;
                            stk_waddr = lvl_addr(r_level - 2'd2);
                            stk_wdata.func = stk_cal.func;
                            stk_wdata.start = stk_cal.start;
                            stk_wdata.child = add_sat48(stk_cal.child, incl);
                        end
                        rec_v = r_edges;
                        rec.kind = KIND_RETURN;
                        rec.func_ref = REF_W'(stk_top.func);
                        rec.caller_ref = (r_level > LV_W'(1)) ?
                                         REF_W'(stk_cal.func) : NONE_REF;
                        rec.inclusive_time = incl;
                        rec.exclusive_time = excl;
                    end
                end
                OP_FRAME: begin
                    rec_v = r_frames;
                    rec.kind = KIND_FRAME;
                    rec.func_ref = r_ftop_func;
                    rec.inclusive_time = r_ftop_time;
                    rec.event_count = r_fcalls;
                    rec.frame_number = inc_sat32(r_frames_seen);
                    rec.frame_script_time = r_fscript;
                end
                default: begin
                    rec_v = 1'b1;
                    rec.kind = KIND_STATS;
                    rec.func_ref = REF_W'(r_fid);
                    if (fid_ok) begin
                        rec.inclusive_time = tab_rdata.incl;
                        rec.exclusive_time = tab_rdata.excl;
                        rec.event_count = tab_rdata.calls;
                        rec.min_time = tab_rdata.tmin;
                        rec.max_time = tab_rdata.tmax;
                        rec.deepest = tab_rdata.deep;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr <= '0;
            r_level <= '0;
            r_edges <= 1'b1;
            r_frames <= 1'b1;
            r_fscript <= '0;
            r_ftop_time <= '0;
            r_fcalls <= '0;
            r_frames_seen <= '0;
            r_ftop_func <= NONE_REF;
            r_ovalid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_EMIT_EDGES) r_edges <= i_cfg_data;
                else r_frames <= i_cfg_data;
            end
            if (r_state == ST_EXEC && r_phase && rec_v) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == FUNCS - 1) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_op <= t_op'(s_axis_tuser);
                        r_fid <= in_fid;
                        r_ts <= s_axis_tdata[55:8];
                        r_phase <= (t_op'(s_axis_tuser) != OP_RETURN);
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_state <= ST_IDLE;
                        if (rec_v) begin
                            r_rec <= rec;
                        end
                        case (r_op)
                            OP_CALL: begin
                                if (!full && fid_ok) begin
                                    r_level <= lvl_new;
                                    r_fcalls <= inc_sat32(r_fcalls);
                                end
                            end
                            OP_RETURN: begin
                                if (!empty) begin
                                    r_level <= r_level - 1'b1;
                                    if (r_level == LV_W'(1)) begin
                                        r_fscript <= add_sat48(r_fscript, incl);
                                        if (incl > r_ftop_time) begin
                                            r_ftop_time <= incl;
                                            r_ftop_func <= REF_W'(stk_top.func);
                                        end
                                    end
                                end
                            end
                            OP_FRAME: begin
                                r_frames_seen <= inc_sat32(r_frames_seen);
                                r_fscript <= '0;
                                r_fcalls <= '0;
                                r_ftop_func <= NONE_REF;
                                r_ftop_time <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_rec.kind;
    assign m_axis_tdata  = {7'b0, r_rec.frame_script_time, r_rec.frame_number,
                            r_rec.deepest, r_rec.max_time, r_rec.min_time,
                            r_rec.event_count, r_rec.exclusive_time,
                            r_rec.inclusive_time, r_rec.caller_ref,
                            r_rec.func_ref};

endmodule

/* test/tb_top.sv */
module tb_top;
    import cstp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FUNCS = 256;
    localparam int STACK_DEPTH = 64;

    typedef struct packed {
        t_kind kind;
        logic [REF_W-1:0] func_ref;
        logic [REF_W-1:0] caller_ref;
        logic [TS_W-1:0] incl;
        logic [TS_W-1:0] excl;
        logic [CNT_W-1:0] count;
        logic [TS_W-1:0] tmin;
        logic [TS_W-1:0] tmax;
        logic [DEEP_W-1:0] deepest;
        logic [CNT_W-1:0] frame_no;
        logic [TS_W-1:0] script;
    } prof_rec_t;

    // Predicts profiler records from the event stream and checks the DUT against them.
    class profile_scoreboard;
        bit en_edges = 1;
        bit en_frames = 1;
        logic [7:0] stk_func[STACK_DEPTH];
        logic [TS_W-1:0] stk_start[STACK_DEPTH];
        logic [TS_W-1:0] stk_child[STACK_DEPTH];
        int level = 0;
        logic [CNT_W-1:0] f_calls[FUNCS];
        int f_active[FUNCS];
        logic [TS_W-1:0] f_incl[FUNCS];
        logic [TS_W-1:0] f_excl[FUNCS];
        logic [TS_W-1:0] f_min[FUNCS];
        logic [TS_W-1:0] f_max[FUNCS];
        int f_deep[FUNCS];
        logic [TS_W-1:0] fr_script = '0;
        logic [CNT_W-1:0] fr_calls = '0;
        logic [REF_W-1:0] fr_top_func = NONE_REF;
        logic [TS_W-1:0] fr_top_time = '0;
        logic [CNT_W-1:0] frames = '0;
        prof_rec_t pending_recs[$];
        int mismatches = 0;
        int checked = 0;
        int overflows = 0;

        function new();
            for (int i = 0; i < FUNCS; i++) begin
                f_calls[i] = 0; f_active[i] = 0; f_incl[i] = 0; f_excl[i] = 0;
                f_min[i] = 0; f_max[i] = 0; f_deep[i] = 0;
            end
        endfunction

        function logic [TS_W-1:0] sat_add(logic [TS_W-1:0] a, logic [TS_W-1:0] b);
            logic [TS_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[TS_W] ? {TS_W{1'b1}} : s[TS_W-1:0];
        endfunction

        function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] a);
            return (&a) ? a : a + 1;
        endfunction

        function void expect_rec(prof_rec_t r);
            pending_recs.insert(pending_recs.size(), r);
        endfunction

        function void note_event(t_op op, logic [7:0] fid, logic [TS_W-1:0] ts);
            prof_rec_t r;
            logic [7:0] f;
            logic [TS_W-1:0] incl, excl, st, ch;
            r = '{KIND_RETURN, NONE_REF, NONE_REF, 0, 0, 0, 0, 0, 0, 0, 0};
            case (op)
                OP_CALL: begin
                    if (level >= STACK_DEPTH) begin
                        r.kind = KIND_OVERFLOW; r.func_ref = REF_W'(fid); r.caller_ref = 0;
                        expect_rec(r);
                        overflows++;
                    end else begin
                        f_calls[fid] = sat_inc(f_calls[fid]);
                        if (f_active[fid] < STACK_DEPTH) f_active[fid]++;
                        stk_func[level] = fid; stk_start[level] = ts; stk_child[level] = 0;
                        level++;
                        if (level > f_deep[fid]) f_deep[fid] = level;
                        fr_calls = sat_inc(fr_calls);
                    end
                end
                OP_RETURN: begin
                    if (level == 0) return;
                    level--;
                    f = stk_func[level]; st = stk_start[level]; ch = stk_child[level];
                    incl = ts > st ? ts - st : 0;
                    excl = incl > ch ? incl - ch : 0;
                    f_excl[f] = sat_add(f_excl[f], excl);
                    if (f_active[f] > 0) f_active[f]--;
                    if (f_active[f] == 0) begin
                        f_incl[f] = sat_add(f_incl[f], incl);
                        if (incl > f_max[f]) f_max[f] = incl;
                        if (f_min[f] == 0 || incl < f_min[f]) f_min[f] = incl;
                    end
                    if (level > 0) begin
                        r.caller_ref = REF_W'(stk_func[level-1]);
                        stk_child[level-1] = sat_add(stk_child[level-1], incl);
                    end else begin
                        fr_script = sat_add(fr_script, incl);
                        if (incl > fr_top_time) begin
                            fr_top_time = incl; fr_top_func = REF_W'(f);
                        end
                    end
                    if (en_edges) begin
                        r.kind = KIND_RETURN; r.func_ref = REF_W'(f);
                        r.incl = incl; r.excl = excl;
                        expect_rec(r);
                    end
                end
                OP_FRAME: begin
                    frames = sat_inc(frames);
                    if (en_frames) begin
                        r.kind = KIND_FRAME; r.caller_ref = 0; r.func_ref = fr_top_func;
                        r.incl = fr_top_time; r.count = fr_calls; r.frame_no = frames;
                        r.script = fr_script;
                        expect_rec(r);
                    end
                    fr_script = 0; fr_calls = 0; fr_top_func = NONE_REF; fr_top_time = 0;
                end
                default: begin
                    r.kind = KIND_STATS; r.caller_ref = 0; r.func_ref = REF_W'(fid);
                    r.incl = f_incl[fid]; r.excl = f_excl[fid]; r.count = f_calls[fid];
                    r.tmin = f_min[fid]; r.tmax = f_max[fid];
                    r.deepest = DEEP_W'(f_deep[fid]);
                    expect_rec(r);
                end
            endcase
        endfunction

        function void check_record(prof_rec_t got);
            prof_rec_t want;
            checked++;
            if (pending_recs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected record kind %0d ref %0d", got.kind, got.func_ref);
                return;
            end
            want = pending_recs.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: record mismatch");
                    $display("  exp kind %0d ref %0d caller %0d incl %0d excl %0d cnt %0d",
                             want.kind, want.func_ref, want.caller_ref, want.incl,
                             want.excl, want.count);
                    $display("      min %0d max %0d deep %0d frame %0d script %0d",
                             want.tmin, want.tmax, want.deepest, want.frame_no, want.script);
                    $display("  got kind %0d ref %0d caller %0d incl %0d excl %0d cnt %0d",
                             got.kind, got.func_ref, got.caller_ref, got.incl,
                             got.excl, got.count);
                    $display("      min %0d max %0d deep %0d frame %0d script %0d",
                             got.tmin, got.tmax, got.deepest, got.frame_no, got.script);
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [335:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic i_cfg_index = 0;
    logic i_cfg_data = 0;

    call_stack_time_profiler dut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    profile_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;
    int events_sent = 0;
    logic [TS_W-1:0] now_ts = 1000;

    // The receiver side runs on its own; records are sampled at the edge.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("ERROR: timeout");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            prof_rec_t g;
            g.kind = t_kind'(m_axis_tuser);
            {g.script, g.frame_no, g.deepest, g.tmax, g.tmin, g.count, g.excl, g.incl,
             g.caller_ref, g.func_ref} = m_axis_tdata[328:0];
            sb.check_record(g);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_event(t_op op, logic [7:0] fid, logic [TS_W-1:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {ts, fid};
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_event(op, fid, ts);
        events_sent++;
    endtask

    task automatic write_reg(logic idx, logic val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_EMIT_EDGES) sb.en_edges = val;
        else sb.en_frames = val;
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending_recs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Advance time mostly forward, sometimes by large steps or backwards.
    function automatic logic [TS_W-1:0] next_ts();
        int r;
        r = $urandom_range(99);
        if (r < 80) now_ts = now_ts + $urandom_range(500);
        else if (r < 90) now_ts = now_ts - $urandom_range(300);
        else if (r < 96) now_ts = TS_W'({$urandom, $urandom});
        else now_ts = MAX48 - $urandom_range(3);
        return now_ts;
    endfunction

    task automatic random_phase(int n, int idle, int stall);
        int r;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (sb.level < 3 && r < 60 || r < 45)
                send_event(OP_CALL, 8'($urandom_range(r < 30 ? 7 : 255)), next_ts());
            else if (r < 85) send_event(OP_RETURN, 8'($urandom), next_ts());
            else if (r < 92)
                send_event(OP_FRAME, 8'($urandom), TS_W'({$urandom, $urandom}));
            else
                send_event(OP_STATS, 8'($urandom_range(r < 97 ? 7 : 255)),
                           TS_W'({$urandom, $urandom}));
        end
        while (sb.level > 0) send_event(OP_RETURN, 0, next_ts());
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: stats of an empty entry, nesting, recursion, backwards clock.
        send_event(OP_STATS, 8'hFF, MAX48);
        send_event(OP_RETURN, 0, 0);
        send_event(OP_CALL, 8'h00, 48'd100);
        send_event(OP_CALL, 8'hFF, 48'd150);
        send_event(OP_CALL, 8'hFF, 48'd160);
        send_event(OP_RETURN, 0, 48'd170);
        send_event(OP_RETURN, 0, 48'd140);
        send_event(OP_RETURN, 0, MAX48);
        send_event(OP_CALL, 8'h00, 48'd0);
        send_event(OP_RETURN, 0, 48'd0);
        send_event(OP_STATS, 8'h00, 0);
        send_event(OP_STATS, 8'hFF, 0);
        send_event(OP_FRAME, 0, 0);
        send_event(OP_FRAME, 0, 0);
        // Fill the stack past its depth to provoke overflow records.
        for (int i = 0; i < STACK_DEPTH + 2; i++)
            send_event(OP_CALL, i[7:0] & 8'h3, TS_W'(1000 + i));
        send_event(OP_STATS, 8'h03, 0);
        while (sb.level > 0) send_event(OP_RETURN, 0, 48'd5000);
        send_event(OP_FRAME, 0, 0);
        drain();

        random_phase(130, 0, 0);
        write_reg(CFG_EMIT_EDGES, 0);
        random_phase(110, 63, 0);
        write_reg(CFG_EMIT_FRAMES, 0);
        write_reg(CFG_EMIT_EDGES, 1);
        random_phase(110, 0, 63);
        write_reg(CFG_EMIT_FRAMES, 1);
        random_phase(130, 21, 21);

        $display("Sent %0d events, checked %0d records, %0d stack overflows.",
                 events_sent, sb.checked, sb.overflows);
        $display("Covered all event kinds, both registers and four idle patterns.");
        if (sb.mismatches == 0 && sb.pending_recs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
